// ----- design/spc_pkg.sv -----
// Shared types and constants for the stack permutation checker.
// No dependencies; compile first.
package spc_pkg;

    localparam int PUSH_COUNT_W = 7;
    localparam int CAP_W        = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PUSH,
        ST_FINISH
    } spc_state_t;

endpackage

// ----- design/spc_car_if.sv -----
// Request channel carrying the next wanted car and the last-car mark.
// Valid/ready handshake; no dependencies.
interface spc_car_if #(parameter int CAR_WIDTH = 16) ();
    logic                 valid;
    logic                 ready;
    logic [CAR_WIDTH-1:0] wanted_car;
    logic                 last_car;

    modport source (output valid, output wanted_car, output last_car, input ready);
    modport sink   (input valid, input wanted_car, input last_car, output ready);
endinterface

// ----- design/spc_move_if.sv -----
// Result channel carrying the moves made for one car and the failure flag.
// Valid/ready handshake; depends on spc_pkg for the push count width.
interface spc_move_if ();
    logic                              valid;
    logic                              ready;
    logic [spc_pkg::PUSH_COUNT_W-1:0]  push_count;
    logic                              popped;
    logic                              failed;

    modport source (output valid, output push_count, output popped, output failed,
                    input ready);
    modport sink   (input valid, input push_count, input popped, input failed,
                    output ready);
endinterface

// ----- design/spc_stack_mem.sv -----
// Stack storage: one write port and one read port with registered read data.
// No package dependencies.
module spc_stack_mem #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/stack_permutation_checker_core.sv -----
// Stack permutation checker top level: sequencer, sequence state, result register.
// Depends on spc_pkg, spc_car_if, spc_move_if and spc_stack_mem.
//
// Usage:
//   cars  : request channel; each request names the next car that must leave
//           (wanted_car) and marks the final car of a sequence (last_car).
//   moves : one result per request: push_count, popped and the sticky failed
//           flag; failed stays set until the request marked last_car.
//   cfg_write_en / cfg_write_data : write stack_capacity (reset 64; values
//           above STACK_DEPTH act as STACK_DEPTH; zero fails every sequence).
// Sequence: a request that needs no push passes through CHECK and FINISH; when P
//   cars are pushed it passes through CHECK, PUSH and FINISH, one stack write per
//   cycle in PUSH through the single memory write port.
//   cars.ready is high only while the sequencer is idle.
// Reset: stack empty, next incoming car 1, failure cleared, capacity 64; the
//   stack memory is not cleared, only entries below the level are ever read.
// Stall: the result register holds one result; a new request is taken while
//   it waits, and the sequencer holds before its result until moves is free.
module stack_permutation_checker_core #(
    parameter int STACK_DEPTH = 64,
    parameter int CAR_WIDTH   = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    spc_car_if.sink                    cars,
    spc_move_if.source                 moves,
    input  logic                       cfg_write_en,
    input  logic [spc_pkg::CAP_W-1:0]  cfg_write_data
);
    import spc_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW    = (LVL_W > CAP_W) ? LVL_W : CAP_W;
    localparam int NI_W  = CAR_WIDTH + 1;

    spc_state_t           state_reg, state_next;
    logic [LVL_W-1:0]     level_reg, level_next;
    logic [NI_W-1:0]      next_inc_reg, next_inc_next;
    logic                 fail_reg, fail_next;
    logic [LVL_W-1:0]     pushes_reg, pushes_next;
    logic                 popped_reg, popped_next;
    logic [CAR_WIDTH-1:0] wanted_reg, wanted_next;
    logic                 last_reg, last_next;
    logic [CAP_W-1:0]     capacity_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [PUSH_COUNT_W-1:0] out_push_reg, out_push_next;
    logic                    out_popped_reg, out_popped_next;
    logic                    out_failed_reg, out_failed_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_wr_addr;
    logic [AW-1:0]        mem_rd_addr;
    logic [CAR_WIDTH-1:0] mem_rd_data;
    logic [LVL_W-1:0]     level_dec;
    logic [CW-1:0]        cap_ext, depth_ext, eff_cap, level_ext;
    logic [NI_W-1:0]      wanted_ext;
    logic [NI_W-1:0]      last_pushed;
    logic [PUSH_COUNT_W+LVL_W-1:0] push_wide;
    logic                 ready_int;

    assign level_dec   = level_reg - LVL_W'(1);
    assign mem_rd_addr = level_dec[AW-1:0];
    assign mem_wr_addr = level_reg[AW-1:0];
    assign cap_ext     = CW'(capacity_reg);
    assign depth_ext   = CW'(STACK_DEPTH);
    assign eff_cap     = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign level_ext   = CW'(level_reg);
    assign wanted_ext  = {1'b0, wanted_reg};
    assign last_pushed = next_inc_reg - NI_W'(1);
    assign push_wide   = {{PUSH_COUNT_W{1'b0}}, pushes_reg};

    spc_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .DATA_W (CAR_WIDTH),
        .ADDR_W (AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (next_inc_reg[CAR_WIDTH-1:0]),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            level_reg      <= '0;
            next_inc_reg   <= NI_W'(1);
            fail_reg       <= 1'b0;
            capacity_reg   <= CAP_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            next_inc_reg  <= next_inc_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                capacity_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pushes_reg     <= pushes_next;
        popped_reg     <= popped_next;
        wanted_reg     <= wanted_next;
        last_reg       <= last_next;
        out_push_reg   <= out_push_next;
        out_popped_reg <= out_popped_next;
        out_failed_reg <= out_failed_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        next_inc_next   = next_inc_reg;
        fail_next       = fail_reg;
        pushes_next     = pushes_reg;
        popped_next     = popped_reg;
        wanted_next     = wanted_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_push_next   = out_push_reg;
        out_popped_next = out_popped_reg;
        out_failed_next = out_failed_reg;
        mem_we          = 1'b0;
        ready_int       = 1'b0;

        if (out_valid_reg && moves.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                ready_int = 1'b1;
                if (cars.valid)
                begin
                    wanted_next = cars.wanted_car;
                    last_next   = cars.last_car;
                    pushes_next = '0;
                    popped_next = 1'b0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_FINISH;
                if (fail_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (level_reg != '0 && mem_rd_data == wanted_reg)
                begin
                    level_next  = level_dec;
                    popped_next = 1'b1;
                end
                else if (level_ext >= eff_cap)
                begin
                    fail_next = 1'b1;
                end
                else if (wanted_ext < next_inc_reg)
                begin
                    fail_next = 1'b1;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (level_ext < eff_cap && next_inc_reg <= wanted_ext)
                begin
                    mem_we        = 1'b1;
                    level_next    = level_reg + LVL_W'(1);
                    next_inc_next = next_inc_reg + NI_W'(1);
                    pushes_next   = pushes_reg + LVL_W'(1);
                end
                else
                begin
                    if (last_pushed == wanted_ext)
                    begin
                        level_next  = level_dec;
                        popped_next = 1'b1;
                    end
                    else
                    begin
                        fail_next = 1'b1;
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || moves.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_push_next   = push_wide[PUSH_COUNT_W-1:0];
                    out_popped_next = popped_reg;
                    out_failed_next = fail_reg;
                    if (last_reg)
                    begin
                        level_next    = '0;
                        next_inc_next = NI_W'(1);
                        fail_next     = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cars.ready       = ready_int;
    assign moves.valid      = out_valid_reg;
    assign moves.push_count = out_push_reg;
    assign moves.popped     = out_popped_reg;
    assign moves.failed     = out_failed_reg;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_ext <= depth_ext)
        else $error("stack level beyond depth");

    a_push_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> level_ext < eff_cap)
        else $error("push beyond capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cars.valid && cars.ready) |=> !cars.ready)
        else $error("request taken while busy");

    a_pop_excludes_fail: assert property (@(posedge clk) disable iff (!rst_n)
        moves.valid |-> !(moves.popped && moves.failed))
        else $error("pop reported with failure");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(moves.valid) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside finish");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for stack_permutation_checker_core: directed and random car orders
// against a built-in bounded-stack predictor, with random idling and backpressure.
// Depends on spc_pkg, spc_car_if, spc_move_if and the design sources.
module tb_top;

    import spc_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int CAR_W       = 16;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_CARS  = 172;

    typedef struct packed {
        logic [CAR_W-1:0] wanted;
        logic             last;
    } car_req_t;

    typedef struct packed {
        logic [PUSH_COUNT_W-1:0] push_count;
        logic                    popped;
        logic                    failed;
    } move_t;

    logic clk;
    logic rst_n;
    logic             cfg_write_en;
    logic [CAP_W-1:0] cfg_write_data;

    spc_car_if #(.CAR_WIDTH(CAR_W)) cars_if ();
    spc_move_if                     moves_if ();

    stack_permutation_checker_core #(
        .STACK_DEPTH (STACK_DEPTH),
        .CAR_WIDTH   (CAR_W)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cars           (cars_if),
        .moves          (moves_if),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    car_req_t pending_cars[$];
    move_t    expected_moves[$];

    logic [CAR_W-1:0] model_stack [STACK_DEPTH];
    int               model_level;
    longint           model_next;
    bit               model_failed;
    logic [CAP_W-1:0] model_cap;

    car_req_t next_car;
    int  send_gap;
    int  send_steady;
    int  hold_left;
    int  recv_steady;
    int  holds_requested;
    int  holds_served;
    bit  calm_finish;
    int  queued_cars;
    int  cars_sent;
    int  moves_checked;
    int  mismatches;
    int  settings_used;
    int  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic move_t predict_moves(input logic [CAR_W-1:0] wanted, input logic last);
        move_t r;
        int    limit;
        r = '0;
        limit = (model_cap > STACK_DEPTH) ? STACK_DEPTH : int'(model_cap);
        if (!model_failed)
        begin
            if (model_level > 0 && model_stack[model_level-1] == wanted)
            begin
                model_level--;
                r.popped = 1'b1;
            end
            else if (model_level >= limit)
                model_failed = 1'b1;
            else if (longint'(wanted) < model_next)
                model_failed = 1'b1;
            else
            begin
                while (model_level < limit && model_next <= longint'(wanted))
                begin
                    model_stack[model_level] = model_next[CAR_W-1:0];
                    model_level++;
                    model_next++;
                    r.push_count++;
                end
                if (model_next - 1 == longint'(wanted))
                begin
                    model_level--;
                    r.popped = 1'b1;
                end
                else
                    model_failed = 1'b1;
            end
        end
        r.failed = model_failed;
        if (last)
        begin
            model_level  = 0;
            model_next   = 1;
            model_failed = 1'b0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic queue_car(input logic [CAR_W-1:0] wanted, input logic last);
        car_req_t c;
        c.wanted = wanted;
        c.last   = last;
        pending_cars.push_back(c);
        queued_cars++;
    endtask

    // Build a feasible order for cars 1..n with at most cap cars held, then maybe break it.
    task automatic queue_stack_order(input int n, input int cap, input bit corrupt,
                                     input int pop_bias);
        int held[$];
        int order[$];
        int next_in;
        int pos;
        next_in = 1;
        while (order.size() < n)
        begin
            if (held.size() > 0 && (next_in > n || held.size() >= cap ||
                                    int'($urandom_range(0, 4)) < pop_bias))
                order.push_back(held.pop_back());
            else
            begin
                held.push_back(next_in);
                next_in++;
            end
        end
        if (corrupt)
        begin
            pos = $urandom_range(0, n - 1);
            order[pos] = $urandom_range(0, n + 2);
        end
        foreach (order[i])
            queue_car(CAR_W'(order[i]), i == n - 1);
    endtask

    task automatic fill_phase(input int target, input int cap);
        int eff;
        int start;
        int kind;
        int k;
        eff = (cap > STACK_DEPTH) ? STACK_DEPTH : ((cap < 1) ? 1 : cap);
        start = queued_cars;
        while (queued_cars - start < target)
        begin
            kind = $urandom_range(0, 15);
            if (kind == 0)
            begin
                k = $urandom_range(1, 4);
                repeat (k)
                    queue_car(CAR_W'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
            end
            else if (kind < 3)
                queue_stack_order($urandom_range(1, 12), eff, 1'b1, $urandom_range(1, 4));
            else if (kind == 3)
                queue_stack_order($urandom_range(eff, eff + 6), eff, 1'b0,
                                  $urandom_range(0, 2));
            else
                queue_stack_order($urandom_range(1, 12), eff, 1'b0, $urandom_range(1, 4));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_cars.size() != 0 || cars_if.valid || expected_moves.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        model_cap = value;
        settings_used++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cars_if.valid      <= 1'b0;
            cars_if.wanted_car <= '0;
            cars_if.last_car   <= 1'b0;
            send_gap           <= 0;
            send_steady        <= 0;
        end
        else
        begin
            if (cars_if.valid && cars_if.ready)
            begin
                expected_moves.push_back(predict_moves(cars_if.wanted_car, cars_if.last_car));
                cars_sent++;
            end
            if (!cars_if.valid || cars_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    cars_if.valid <= 1'b0;
                end
                else if (pending_cars.size() > 0)
                begin
                    next_car = pending_cars.pop_front();
                    cars_if.wanted_car <= next_car.wanted;
                    cars_if.last_car   <= next_car.last;
                    cars_if.valid      <= 1'b1;
                    if (send_steady > 0)
                        send_steady <= send_steady - 1;
                    else if (!calm_finish)
                    begin
                        case ($urandom_range(0, 7))
                            0: send_gap <= $urandom_range(1, 13);
                            1: send_steady <= $urandom_range(10, 40);
                            default: ;
                        endcase
                    end
                end
                else
                    cars_if.valid <= 1'b0;
            end
        end
    end

    // result ready control
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moves_if.ready <= 1'b0;
            hold_left      <= 0;
            recv_steady    <= 0;
            holds_served   <= 0;
        end
        else if (hold_left > 0)
        begin
            moves_if.ready <= 1'b0;
            hold_left      <= hold_left - 1;
        end
        else if (holds_served != holds_requested)
        begin
            holds_served   <= holds_served + 1;
            hold_left      <= LONG_HOLD - 1;
            moves_if.ready <= 1'b0;
        end
        else if (calm_finish)
            moves_if.ready <= 1'b1;
        else if (recv_steady > 0)
        begin
            recv_steady    <= recv_steady - 1;
            moves_if.ready <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    moves_if.ready <= 1'b0;
                    hold_left      <= $urandom_range(0, 12);
                end
                1:
                begin
                    moves_if.ready <= 1'b1;
                    recv_steady    <= $urandom_range(20, 80);
                end
                default: moves_if.ready <= 1'b1;
            endcase
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && moves_if.valid && moves_if.ready)
        begin
            if (expected_moves.size() == 0)
                flag_mismatch($sformatf(
                    "result with none expected: push_count=%0d popped=%0b failed=%0b",
                    moves_if.push_count, moves_if.popped, moves_if.failed));
            else
            begin
                move_t want;
                want = expected_moves.pop_front();
                moves_checked++;
                if (moves_if.push_count !== want.push_count)
                    flag_mismatch($sformatf("result %0d push_count exp %0d got %0d",
                                            moves_checked, want.push_count, moves_if.push_count));
                if (moves_if.popped !== want.popped)
                    flag_mismatch($sformatf("result %0d popped exp %0b got %0b",
                                            moves_checked, want.popped, moves_if.popped));
                if (moves_if.failed !== want.failed)
                    flag_mismatch($sformatf("result %0d failed exp %0b got %0b",
                                            moves_checked, want.failed, moves_if.failed));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_moves.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int phase_caps[10];
        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_write_data     = '0;
        calm_finish        = 1'b0;
        holds_requested    = 0;
        model_cap          = CAP_RESET;
        model_level        = 0;
        model_next         = 1;
        model_failed       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        queue_car(16'd1, 1'b1);
        queue_car(16'd3, 1'b0);
        queue_car(16'd2, 1'b0);
        queue_car(16'd1, 1'b1);
        queue_car(16'd1, 1'b0);
        queue_car(16'd3, 1'b0);
        queue_car(16'd1, 1'b0);
        queue_car(16'd2, 1'b1);
        queue_car(16'd0, 1'b1);
        queue_car(16'hFFFF, 1'b1);
        queue_car(16'd64, 1'b0);
        queue_car(16'd63, 1'b0);
        queue_car(16'd62, 1'b1);
        queue_car(16'd10, 1'b0);
        wait_drained();
        // shrink capacity under a partly filled stack
        write_capacity(7'd5);
        queue_car(16'd11, 1'b0);
        queue_car(16'd11, 1'b1);
        queue_car(16'd2, 1'b0);
        queue_car(16'd1, 1'b1);
        wait_drained();
        write_capacity(7'd0);
        queue_car(16'd1, 1'b1);
        wait_drained();
        write_capacity(7'd127);
        queue_car(16'd65, 1'b1);
        queue_car(16'd64, 1'b1);
        wait_drained();

        phase_caps = '{0, 1, 127, 2, 64, $urandom_range(3, 63), $urandom_range(3, 63),
                       $urandom_range(65, 126), $urandom_range(3, 63), 64};
        foreach (phase_caps[p])
        begin
            write_capacity(CAP_W'(phase_caps[p]));
            if (p == 4)
                holds_requested++;
            if (p == 9)
                calm_finish = 1'b1;
            fill_phase(PHASE_CARS, phase_caps[p]);
            wait_drained();
        end

        repeat (STACK_DEPTH + 8) @(posedge clk);
        mismatches += expected_moves.size();
        $display("%0d car requests sent, %0d results checked across %0d capacity writes",
                 cars_sent, moves_checked, settings_used);
        $display("capacities included 0, 1, 2, 64, 127 and random values; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
